@@ rtl/core/mcfir_pkg.sv @@
// Shared types and constants of the multichannel FIR filter.
`timescale 1ns / 1ps
`default_nettype none

package mcfir_pkg;

  // Number of lanes and sample fields carried by one transaction
  localparam int LANES = 4;
  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int FRAC_W = 15;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [5:0] TAP_COUNT_RESET = 6'd32;
  localparam logic [2:0] CHANNEL_COUNT_RESET = 3'd4;

  // Command codes
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [4:0]               coeff_index;
    logic signed [DATA_W-1:0] coeff_value;
    logic signed [DATA_W-1:0] sample_0;
    logic signed [DATA_W-1:0] sample_1;
    logic signed [DATA_W-1:0] sample_2;
    logic signed [DATA_W-1:0] sample_3;
  } mcfir_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_0;
    logic signed [DATA_W-1:0] result_1;
    logic signed [DATA_W-1:0] result_2;
    logic signed [DATA_W-1:0] result_3;
  } mcfir_rsp_t;

  // Pipeline strobes broadcast from the sequencer to every lane
  typedef struct packed {
    logic iss_rd;
    logic s1_valid;
    logic s1_tap0;
    logic s2_valid;
    logic s2_start;
  } mcfir_step_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } mcfir_state_t;

endpackage

`default_nettype wire

@@ rtl/core/mcfir_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mcfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mcfir_lane.sv @@
// One filter lane: delay line memory, shift-on-read and multiply-accumulate.
`timescale 1ns / 1ps
`default_nettype none

module mcfir_lane
  import mcfir_pkg::*;
#(
  parameter int MAX_TAPS = 32,
  parameter int TAP_W = 5,
  parameter int ACC_W = 37
) (
  input  wire logic                     clk,
  input  wire mcfir_step_t              step,
  input  wire logic                     lane_en,
  input  wire logic                     clear_en,
  input  wire logic [TAP_W-1:0]         rd_addr,
  input  wire logic [TAP_W-1:0]         wr_addr,
  input  wire logic signed [DATA_W-1:0] sample,
  input  wire logic signed [DATA_W-1:0] coeff,
  output logic signed [ACC_W-1:0]       acc
);

  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] tap_val;
  logic signed [PROD_W-1:0] prod;
  logic                     we;
  logic [DATA_W-1:0]        wdata;

  // New tap value: fresh sample at tap 0, else the entry one tap below
  assign tap_val = step.s1_tap0 ? sample : $signed(rdata);

  // Write back the shifted entry, or zero during the clearing pass
  assign we    = clear_en || (step.s1_valid && lane_en);
  assign wdata = clear_en ? '0 : tap_val;

  mcfir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_TAPS)
  ) u_delay (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (step.iss_rd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Multiply stage
  always_ff @(posedge clk) begin
    if (step.s1_valid) begin
      prod <= PROD_W'(tap_val) * PROD_W'(coeff);
    end
  end

  // Accumulate stage, restart on the first tap of a transaction
  always_ff @(posedge clk) begin
    if (step.s2_valid) begin
      if (step.s2_start) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mcfir_merge.sv @@
// Merge stage: round, saturate and register the lane sums as one result.
`timescale 1ns / 1ps
`default_nettype none

module mcfir_merge
  import mcfir_pkg::*;
#(
  parameter int ACC_W = 37
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [LANES-1:0]       lane_en,
  input  wire logic signed [ACC_W-1:0] acc [LANES],
  input  wire logic                   rsp_stall,
  output logic                        rsp_valid,
  output mcfir_rsp_t                  rsp
);

  localparam int X_W = ACC_W + 1;
  localparam logic signed [X_W-1:0] ROUND_BIAS = X_W'(1 << (FRAC_W - 1));
  localparam logic signed [X_W-1:0] SAT_HI = X_W'(32767);
  localparam logic signed [X_W-1:0] SAT_LO = -X_W'(32768);

  logic signed [DATA_W-1:0] res [LANES];

  // Add half an LSB, floor by arithmetic shift, clamp to Q15
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] q;
    x = X_W'(a) + ROUND_BIAS;
    q = x >>> FRAC_W;
    if (q > SAT_HI) begin
      return DATA_W'(SAT_HI);
    end else if (q < SAT_LO) begin
      return DATA_W'(SAT_LO);
    end
    return q[DATA_W-1:0];
  endfunction

  // Zero inactive lanes
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      res[c] = lane_en[c] ? round_sat(acc[c]) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.result_0 <= res[0];
      rsp.result_1 <= res[1];
      rsp.result_2 <= res[2];
      rsp.result_3 <= res[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/multichannel_fir_filter_unit.sv @@
// Top level of the multichannel FIR filter: sequencer, coefficient store and lanes.
`timescale 1ns / 1ps
`default_nettype none

// Multichannel direct-form FIR filter with one shared Q1.15 coefficient set. A filter
// transaction carries one Q15 sample per channel; every active channel shifts its delay
// line and returns the rounded, saturated dot product with the coefficients. One lane per
// channel works in parallel, each doing one multiply-accumulate per tap per cycle; a filter
// transaction occupies the block through a pipeline of read, multiply, accumulate and
// merge, and a coefficient load gives no result. The next transaction may be accepted
// while a result waits in the output register. After reset the block runs a clearing
// pass over every address of the delay lines and the coefficient store, during which it
// stalls requests; configuration writes are taken at any time.
module multichannel_fir_filter_unit
  import mcfir_pkg::*;
#(
  parameter int MAX_TAPS = 32,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire mcfir_req_t            req,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output mcfir_rsp_t                 rsp,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam logic [TAP_W-1:0] LAST_ADDR = TAP_W'(MAX_TAPS - 1);

  mcfir_state_t state, state_next;

  logic [5:0]       tap_count;
  logic [2:0]       channel_count;
  logic [TAP_W-1:0] last_tap;
  logic [2:0]       eff_chans;
  logic [LANES-1:0] lane_en;

  logic             accept;
  logic             issue;
  logic             clear_en;
  logic             merge_load;
  logic             coeff_we;
  logic [TAP_W-1:0] coeff_waddr;
  logic [31:0]      coeff_idx32;
  logic [DATA_W-1:0] coeff_rdata;

  logic [TAP_W-1:0] clr_addr;
  logic [TAP_W-1:0] tap_cnt;
  logic [TAP_W-1:0] s1_addr;
  logic             s1_valid, s1_tap0, s1_start;
  logic             s2_valid, s2_tap0, s2_start;
  logic             acc_ready;
  logic [TAP_W-1:0] wr_addr;
  logic [TAP_W-1:0] rd_addr;

  mcfir_step_t              step;
  logic signed [DATA_W-1:0] samp [LANES];
  logic signed [ACC_W-1:0]  acc [LANES];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count     <= TAP_COUNT_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAP_COUNT:     tap_count <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their usable ranges
  always_comb begin
    int et;
    int ec;
    et = (tap_count == '0) ? 1 : ((int'(tap_count) > MAX_TAPS) ? MAX_TAPS : int'(tap_count));
    ec = (channel_count == '0) ? 1 :
         ((int'(channel_count) > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_count));
    last_tap  = TAP_W'(et - 1);
    eff_chans = 3'(ec);
    for (int c = 0; c < LANES; c++) begin
      lane_en[c] = (3'(c) < eff_chans);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (req.command == CMD_FILTER)) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (tap_cnt == '0) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (merge_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall  = (state != ST_IDLE);
    clear_en   = (state == ST_CLEAR);
    issue      = (state == ST_RUN);
    merge_load = (state == ST_DRAIN) && acc_ready && (!rsp_valid || !rsp_stall);
  end

  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clear_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Hold the samples and walk the taps from the top down
  always_ff @(posedge clk) begin
    if (accept) begin
      samp[0] <= req.sample_0;
      samp[1] <= req.sample_1;
      samp[2] <= req.sample_2;
      samp[3] <= req.sample_3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_cnt <= '0;
    end else if (accept && (req.command == CMD_FILTER)) begin
      tap_cnt <= last_tap;
    end else if (issue && (tap_cnt != '0)) begin
      tap_cnt <= tap_cnt - 1'b1;
    end
  end

  // Advance the read / multiply / accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_tap0   <= 1'b0;
      s1_start  <= 1'b0;
      s2_valid  <= 1'b0;
      s2_tap0   <= 1'b0;
      s2_start  <= 1'b0;
      acc_ready <= 1'b0;
    end else begin
      s1_valid <= issue;
      s1_tap0  <= issue && (tap_cnt == '0);
      s1_start <= issue && (tap_cnt == last_tap);
      s2_valid <= s1_valid;
      s2_tap0  <= s1_tap0;
      s2_start <= s1_start;
      if (s2_valid && s2_tap0) begin
        acc_ready <= 1'b1;
      end else if (merge_load) begin
        acc_ready <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr <= tap_cnt;
    end
  end

  assign step.iss_rd   = issue && (tap_cnt != '0);
  assign step.s1_valid = s1_valid;
  assign step.s1_tap0  = s1_tap0;
  assign step.s2_valid = s2_valid;
  assign step.s2_start = s2_start;

  assign rd_addr = tap_cnt - 1'b1;
  assign wr_addr = clear_en ? clr_addr : s1_addr;

  // Coefficient store: loads while idle, zeros during the clearing pass
  assign coeff_idx32 = 32'(req.coeff_index);
  assign coeff_we    = clear_en ||
                       (accept && (req.command == CMD_LOAD) && (coeff_idx32 < 32'(MAX_TAPS)));
  assign coeff_waddr = clear_en ? clr_addr : coeff_idx32[TAP_W-1:0];

  mcfir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_TAPS)
  ) u_coeff (
    .clk   (clk),
    .we    (coeff_we),
    .waddr (coeff_waddr),
    .wdata (clear_en ? {DATA_W{1'b0}} : req.coeff_value),
    .re    (issue),
    .raddr (tap_cnt),
    .rdata (coeff_rdata)
  );

  // One lane per channel
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_on
      mcfir_lane #(
        .MAX_TAPS (MAX_TAPS),
        .TAP_W    (TAP_W),
        .ACC_W    (ACC_W)
      ) u_lane (
        .clk      (clk),
        .step     (step),
        .lane_en  (lane_en[c]),
        .clear_en (clear_en),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .sample   (samp[c]),
        .coeff    ($signed(coeff_rdata)),
        .acc      (acc[c])
      );
    end else begin : g_off
      assign acc[c] = '0;
    end
  end

  mcfir_merge #(
    .ACC_W (ACC_W)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (merge_load),
    .lane_en   (lane_en),
    .acc       (acc),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ tb/tb_multichannel_fir_filter_unit.sv @@
// Self-checking testbench of the multichannel FIR filter with a transaction-level predictor.
`timescale 1ns / 1ps

module tb_multichannel_fir_filter_unit;
  import mcfir_pkg::*;

  localparam int TAPS_MAX = 32;
  localparam int CHANS_MAX = 4;
  // Drain margin after the last expected output; allow a wide margin
  localparam int SETTLE_CYCLES = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int PHASES = 16;
  localparam int FIXED_SETTINGS = 8;
  localparam int MAX_REPORTS = 10;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Settings walked first: edges, out-of-range values, then a few ordinary ones
  localparam int FIXED_TAPS [FIXED_SETTINGS] = '{1, 0, 63, 33, 32, 2, 31, 16};
  localparam int FIXED_CHANS [FIXED_SETTINGS] = '{1, 0, 7, 5, 1, 4, 3, 2};

  typedef struct {
    mcfir_req_t item;
    bit         literal;
    mcfir_rsp_t want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  mcfir_req_t            req = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  mcfir_rsp_t            rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state
  logic signed [DATA_W-1:0] line_q [CHANS_MAX][TAPS_MAX];
  logic signed [DATA_W-1:0] coef_q [TAPS_MAX];
  logic [5:0]               taps_cfg = TAP_COUNT_RESET;
  logic [2:0]               chans_cfg = CHANNEL_COUNT_RESET;

  mcfir_rsp_t pending_outputs [$];
  row_t       script [$];
  int         failures = 0;
  int         req_quiet = 0;
  int         rsp_quiet = 0;
  int         rsp_hold = 0;
  int         idle_cycles = 0;

  multichannel_fir_filter_unit dut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Draw a wait count in 0..9, with occasional stretches of no waiting
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Pick a 16-bit word, biased toward the extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mcfir_req_t random_item();
    mcfir_req_t it;
    it.command = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_FILTER;
    it.coeff_index = 5'($urandom);
    it.coeff_value = pick_word();
    it.sample_0 = pick_word();
    it.sample_1 = pick_word();
    it.sample_2 = pick_word();
    it.sample_3 = pick_word();
    return it;
  endfunction

  function automatic row_t mk_row(input logic cmd, input logic [4:0] idx,
                                  input logic [15:0] cv, input logic [15:0] s0,
                                  input logic [15:0] s1, input logic [15:0] s2,
                                  input logic [15:0] s3, input bit lit,
                                  input logic [15:0] r0, input logic [15:0] r1,
                                  input logic [15:0] r2, input logic [15:0] r3);
    row_t r;
    r.item = '{command: cmd, coeff_index: idx, coeff_value: cv,
               sample_0: s0, sample_1: s1, sample_2: s2, sample_3: s3};
    r.literal = lit;
    r.want = '{result_0: r0, result_1: r1, result_2: r2, result_3: r3};
    return r;
  endfunction

  // Apply one request to the filter state; return 1 with the output when one is produced
  function automatic bit filter_step(input mcfir_req_t it, output mcfir_rsp_t y);
    int n_taps;
    int n_chans;
    logic signed [DATA_W-1:0] smp [CHANS_MAX];
    logic signed [DATA_W-1:0] lane_out [CHANS_MAX];
    logic signed [47:0] acc;
    logic signed [47:0] rounded;
    y = '0;
    if (it.command == CMD_LOAD) begin
      coef_q[it.coeff_index] = it.coeff_value;
      return 1'b0;
    end
    n_taps = (int'(taps_cfg) == 0) ? 1 :
             (int'(taps_cfg) > TAPS_MAX) ? TAPS_MAX : int'(taps_cfg);
    n_chans = (int'(chans_cfg) == 0) ? 1 :
              (int'(chans_cfg) > CHANS_MAX) ? CHANS_MAX : int'(chans_cfg);
    smp[0] = it.sample_0;
    smp[1] = it.sample_1;
    smp[2] = it.sample_2;
    smp[3] = it.sample_3;
    for (int c = 0; c < CHANS_MAX; c++) begin
      lane_out[c] = '0;
      if (c < n_chans) begin
        // Shift only the taps in use, then take the dot product
        for (int t = n_taps - 1; t > 0; t--) line_q[c][t] = line_q[c][t-1];
        line_q[c][0] = smp[c];
        acc = '0;
        for (int t = 0; t < n_taps; t++) acc = acc + 48'(line_q[c][t]) * 48'(coef_q[t]);
        // Round half up, then saturate to Q15
        rounded = (acc + 48'sd16384) >>> FRAC_W;
        if (rounded > 48'sd32767) lane_out[c] = 16'sh7FFF;
        else if (rounded < -48'sd32768) lane_out[c] = 16'sh8000;
        else lane_out[c] = rounded[15:0];
      end
    end
    y.result_0 = lane_out[0];
    y.result_1 = lane_out[1];
    y.result_2 = lane_out[2];
    y.result_3 = lane_out[3];
    return 1'b1;
  endfunction

  // Send one request transaction after a random gap; predict at acceptance
  task automatic send_item(input mcfir_req_t item, input bit literal, input mcfir_rsp_t want);
    int gap;
    mcfir_rsp_t predicted;
    gap = draw_wait(req_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (filter_step(item, predicted)) pending_outputs.push_back(literal ? want : predicted);
  endtask

  // Write one register; leave valid high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TAP_COUNT: taps_cfg = data;
      CFG_CHANNEL_COUNT: chans_cfg = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_filter_config(input int taps, input int chans);
    if ($urandom_range(0, 1) != 0)
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, 6'($urandom));
    write_reg(CFG_TAP_COUNT, 6'(taps));
    write_reg(CFG_CHANNEL_COUNT, 6'(chans));
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected output, then let the pipeline drain
  task automatic settle();
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles after each output transaction
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) begin
      rsp_hold = draw_wait(rsp_quiet);
      rsp_stall <= (rsp_hold != 0);
    end else if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_stall <= (rsp_hold != 0);
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    mcfir_rsp_t want;
    logic [3:0] bad;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_outputs.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("unexpected output: %0d %0d %0d %0d",
                   rsp.result_0, rsp.result_1, rsp.result_2, rsp.result_3);
        failures++;
      end else begin
        want = pending_outputs.pop_front();
        bad[0] = rsp.result_0 !== want.result_0;
        bad[1] = rsp.result_1 !== want.result_1;
        bad[2] = rsp.result_2 !== want.result_2;
        bad[3] = rsp.result_3 !== want.result_3;
        if (|bad) begin
          if (failures < MAX_REPORTS)
            $display("output differs (lanes %b): expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     bad, want.result_0, want.result_1, want.result_2, want.result_3,
                     rsp.result_0, rsp.result_1, rsp.result_2, rsp.result_3);
          failures++;
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("multichannel_fir_filter_unit: mismatch");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    foreach (line_q[c, t]) line_q[c][t] = '0;
    foreach (coef_q[t]) coef_q[t] = '0;

    // Directed rows at the reset setting; literals where the output is obvious
    // cmd         idx    coeff     s0        s1        s2        s3        lit outputs
    script.push_back(mk_row(CMD_FILTER, 5'd31, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                            1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    script.push_back(mk_row(CMD_LOAD, 5'd0, 16'h8000, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                            1'b0, '0, '0, '0, '0));
    // Full-scale negative times full-scale negative saturates
    script.push_back(mk_row(CMD_FILTER, 5'd5, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                            1'b1, 16'h7FFF, 16'h8001, 16'h0000, 16'hFFFF));
    script.push_back(mk_row(CMD_LOAD, 5'd0, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            1'b0, '0, '0, '0, '0));
    // Rounding ties go toward plus infinity
    script.push_back(mk_row(CMD_FILTER, 5'd0, 16'h0000, 16'h4000, 16'hC000, 16'h3FFF, 16'hBFFF,
                            1'b1, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF));
    script.push_back(mk_row(CMD_LOAD, 5'd31, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_LOAD, 5'd31, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_LOAD, 5'd0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_LOAD, 5'd1, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_LOAD, 5'd15, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_LOAD, 5'd16, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_FILTER, 5'd31, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_FILTER, 5'd0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_FILTER, 5'd16, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_FILTER, 5'd15, 16'h5555, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_LOAD, 5'd2, 16'h8000, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_FILTER, 5'd0, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                            1'b0, '0, '0, '0, '0));
    script.push_back(mk_row(CMD_FILTER, 5'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            1'b0, '0, '0, '0, '0));

    // Hold reset, then run the directed rows and a phase of random traffic at the reset setting
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) send_item(script[i].item, script[i].literal, script[i].want);
    for (int k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_item(), 1'b0, '0);

    // Change the setting only with the block idle, then run random traffic
    for (int p = 0; p < PHASES; p++) begin
      req_valid <= 1'b0;
      settle();
      if (p < FIXED_SETTINGS) set_filter_config(FIXED_TAPS[p], FIXED_CHANS[p]);
      else set_filter_config($urandom_range(0, 63), $urandom_range(0, 7));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_item(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    settle();

    failures = failures + pending_outputs.size();
    if (failures == 0)
      $display("multichannel_fir_filter_unit: match");
    else
      $display("multichannel_fir_filter_unit: mismatch");
    $finish;
  end

endmodule
